// ----- sv/tccs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the text console cursor/scroll sequencer.
// Types, codes and fixed widths shared by the interfaces and the modules.
package tccs_pkg;

  // Fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CODE_W  = 7;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned LINE_W  = 10;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned ROWS_W  = 7;
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned TAB_W   = 4;
  // Modulo unit: dividend is offset plus row line (< 2048), remainder < 1024
  localparam int unsigned DIV_W   = 11;
  localparam int unsigned REM_W   = 10;

  localparam int unsigned TAB_STOP = 8;
  localparam int unsigned MAX_ROWS = 64;

  // Character codes (7-bit)
  localparam logic [CODE_W-1:0] CH_BEL   = 7'h07;
  localparam logic [CODE_W-1:0] CH_BS    = 7'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 7'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 7'h0a;
  localparam logic [CODE_W-1:0] CH_CR    = 7'h0d;
  localparam logic [CODE_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CODE_W-1:0] CH_TILDE = 7'h7e;

  // Register reset values
  localparam logic [ROWS_W-1:0] RST_TEXT_ROWS = 7'd30;
  localparam logic [COL_W-1:0]  RST_TEXT_COLS = 7'd80;
  localparam logic [PIX_W-1:0]  RST_X_LIMIT   = 10'd752;
  localparam logic [PIX_W-1:0]  RST_Y_LIMIT   = 10'd464;
  localparam logic [LINE_W-1:0] RST_SCAN_BASE = 10'd0;
  localparam logic              RST_BELL      = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TEXT_ROWS = 3'd0,
    CFG_TEXT_COLS = 3'd1,
    CFG_X_LIMIT   = 3'd2,
    CFG_Y_LIMIT   = 3'd3,
    CFG_SCAN_BASE = 3'd4,
    CFG_BELL      = 3'd5
  } cfg_idx_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_DRAW   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_CURSOR = 2'd2,
    ACT_BELL   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GLYPH,
    S_GMOD,
    S_GEMIT,
    S_LF,
    S_LMOD,
    S_LEMIT,
    S_CURSOR,
    S_BELL
  } state_e;

  // Request to and status from the modulo unit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] modulus;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic [REM_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ----- sv/tccs_in_if.sv -----
`timescale 1ns / 1ps
// Character input channel: valid/ready handshake with one character byte.
// Depends on tccs_pkg for the field width.
interface tccs_in_if;
  logic                          valid;
  logic                          ready;
  logic [tccs_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ----- sv/tccs_out_if.sv -----
`timescale 1ns / 1ps
// Display command channel: valid/ready handshake with one command per transfer.
// Depends on tccs_pkg for the field widths.
interface tccs_out_if;
  logic                          valid;
  logic                          ready;
  logic [tccs_pkg::ACT_W-1:0]    action;
  logic [tccs_pkg::CODE_W-1:0]   glyph_index;
  logic [tccs_pkg::LINE_W-1:0]   pixel_line;
  logic [tccs_pkg::COL_W-1:0]    column;
  logic [tccs_pkg::PIX_W-1:0]    cursor_x;
  logic [tccs_pkg::PIX_W-1:0]    cursor_y;
  logic                          last;

  modport source (output valid, output action, output glyph_index, output pixel_line,
                  output column, output cursor_x, output cursor_y, output last,
                  input ready);
  modport sink   (input valid, input action, input glyph_index, input pixel_line,
                  input column, input cursor_x, input cursor_y, input last,
                  output ready);
endinterface

// ----- sv/tccs_mod.sv -----
`timescale 1ns / 1ps
// Iterative modulo unit: restoring compare/subtract, one quotient bit a cycle.
// Depends on tccs_pkg for widths and the request/status structs.
module tccs_mod #(
  parameter int unsigned STEPS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tccs_pkg::mod_req_t  req_i,
  output tccs_pkg::mod_rsp_t  rsp_o
);

  localparam int unsigned DSR_W = tccs_pkg::DIV_W + STEPS - 1;
  localparam int unsigned CNT_W = (STEPS > 2) ? $clog2(STEPS) : 1;

  logic                        busy_q, busy_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [tccs_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [DSR_W-1:0]            dsr_q, dsr_d;
  logic [DSR_W-1:0]            rem_ext;

  assign rem_ext = {{(STEPS-1){1'b0}}, rem_q};

  // One compare/subtract per cycle against the shifted modulus
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(STEPS - 1);
      rem_d  = req_i.dividend;
      dsr_d  = {req_i.modulus, {(STEPS-1){1'b0}}};
    end else if (busy_q) begin
      if (rem_ext >= dsr_q) begin
        rem_d = rem_q - dsr_q[tccs_pkg::DIV_W-1:0];
      end
      dsr_d = dsr_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.rem  = rem_q[tccs_pkg::REM_W-1:0];

endmodule

// ----- sv/text_console_cursor_scroll.sv -----
`timescale 1ns / 1ps
// Text console sequencer: characters in, draw/clear/cursor/bell commands out.
// Depends on tccs_pkg, tccs_in_if, tccs_out_if and tccs_mod.
//
// Usage: characters arrive on in_i (valid/ready); the low 7 bits are decoded.
// Each character produces zero to seventeen commands on out_o, the final one
// flagged with last. The user writes registers through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the block is idle; the block itself does not enforce this. Indexes beyond
// the register list are ignored. One character is in work at a time; in_i.ready is
// high only between items. The shared modulo unit reduces the scan line of a text
// row one quotient bit per cycle, in 12 - clog2(GLYPH_HEIGHT+1) steps (8 at the default),
// for each drawn glyph and for each scroll.
// A single output register holds each command; while the receiver stalls the
// sequencer waits in place and resumes on the next transfer. The next
// character can be accepted while the final command still waits.
// Reset clears the cursor, the scroll offset and loads register defaults.
module text_console_cursor_scroll #(
  parameter int unsigned GLYPH_HEIGHT = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tccs_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  logic [tccs_pkg::CFG_W-1:0]      cfg_data_i,
  tccs_in_if.sink                         in_i,
  tccs_out_if.source                      out_o
);

  localparam int unsigned GH_W   = $clog2(GLYPH_HEIGHT + 1);
  localparam int unsigned STEPS  = 12 - $clog2(GLYPH_HEIGHT + 1);
  localparam int unsigned ROWP_W = tccs_pkg::ROW_W + GH_W;
  localparam int unsigned MP_W   = tccs_pkg::ROWS_W + GH_W;

  // Configuration registers
  logic [tccs_pkg::ROWS_W-1:0] text_rows_q;
  logic [tccs_pkg::COL_W-1:0]  text_cols_q;
  logic [tccs_pkg::PIX_W-1:0]  x_limit_q;
  logic [tccs_pkg::PIX_W-1:0]  y_limit_q;
  logic [tccs_pkg::LINE_W-1:0] scan_base_q;
  logic                        bell_q;

  // Sequencer state
  tccs_pkg::state_e            state_q, state_d;
  logic [tccs_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tccs_pkg::COL_W-1:0]  col_q, col_d;
  logic [tccs_pkg::LINE_W-1:0] off_q, off_d;
  logic [tccs_pkg::TAB_W-1:0]  tab_cnt_q, tab_cnt_d;
  logic [tccs_pkg::CODE_W-1:0] glyph_q, glyph_d;
  logic [tccs_pkg::DIV_W-1:0]  m_q, m_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [tccs_pkg::ACT_W-1:0]  act_q, act_d;
  logic [tccs_pkg::CODE_W-1:0] oglyph_q, oglyph_d;
  logic [tccs_pkg::LINE_W-1:0] line_q, line_d;
  logic [tccs_pkg::COL_W-1:0]  ocol_q, ocol_d;
  logic [tccs_pkg::PIX_W-1:0]  cx_q, cx_d;
  logic [tccs_pkg::PIX_W-1:0]  cy_q, cy_d;
  logic                        last_q, last_d;

  tccs_pkg::mod_req_t          mod_req;
  tccs_pkg::mod_rsp_t          mod_rsp;

  logic                        in_fire;
  logic                        slot_free;
  logic [tccs_pkg::CODE_W-1:0] code;
  logic [tccs_pkg::ROWS_W-1:0] eff_rows;
  logic [tccs_pkg::ROWS_W-1:0] row_inc;
  logic [ROWP_W-1:0]           row_prod;
  logic [MP_W-1:0]             m_prod;
  logic [tccs_pkg::PIX_W-1:0]  x_raw;
  logic [tccs_pkg::COL_W:0]    col_inc;
  logic [tccs_pkg::DIV_W-1:0]  off_sum;
  logic [tccs_pkg::LINE_W-1:0] rem_line;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_rows_q <= tccs_pkg::RST_TEXT_ROWS;
      text_cols_q <= tccs_pkg::RST_TEXT_COLS;
      x_limit_q   <= tccs_pkg::RST_X_LIMIT;
      y_limit_q   <= tccs_pkg::RST_Y_LIMIT;
      scan_base_q <= tccs_pkg::RST_SCAN_BASE;
      bell_q      <= tccs_pkg::RST_BELL;
    end else if (cfg_we_i) begin
      unique case (tccs_pkg::cfg_idx_e'(cfg_idx_i))
        tccs_pkg::CFG_TEXT_ROWS: text_rows_q <= cfg_data_i[tccs_pkg::ROWS_W-1:0];
        tccs_pkg::CFG_TEXT_COLS: text_cols_q <= cfg_data_i[tccs_pkg::COL_W-1:0];
        tccs_pkg::CFG_X_LIMIT:   x_limit_q   <= cfg_data_i;
        tccs_pkg::CFG_Y_LIMIT:   y_limit_q   <= cfg_data_i;
        tccs_pkg::CFG_SCAN_BASE: scan_base_q <= cfg_data_i;
        tccs_pkg::CFG_BELL:      bell_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Shared modulo unit
  tccs_mod #(
    .STEPS (STEPS)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Datapath helpers
  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign code      = in_i.char_code[tccs_pkg::CODE_W-1:0];

  // Row count 0 acts as 1, above 64 acts as 64
  always_comb begin
    if (text_rows_q == '0) begin
      eff_rows = tccs_pkg::ROWS_W'(1);
    end else if (text_rows_q > tccs_pkg::ROWS_W'(tccs_pkg::MAX_ROWS)) begin
      eff_rows = tccs_pkg::ROWS_W'(tccs_pkg::MAX_ROWS);
    end else begin
      eff_rows = text_rows_q;
    end
  end

  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_prod = ROWP_W'(row_q) * ROWP_W'(GLYPH_HEIGHT);
  assign m_prod   = MP_W'(eff_rows) * MP_W'(GLYPH_HEIGHT);
  assign x_raw    = {col_q, 3'b000};
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign off_sum  = {1'b0, mod_rsp.rem} + tccs_pkg::DIV_W'(GLYPH_HEIGHT);
  assign rem_line = scan_base_q + mod_rsp.rem;

  // Sequencer: next state and command generation
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    off_d       = off_q;
    tab_cnt_d   = tab_cnt_q;
    glyph_d     = glyph_q;
    m_d         = m_q;
    out_valid_d = out_valid_q && !out_o.ready;
    act_d       = act_q;
    oglyph_d    = oglyph_q;
    line_d      = line_q;
    ocol_d      = ocol_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    last_d      = last_q;
    mod_req.start    = 1'b0;
    mod_req.dividend = {1'b0, off_q} + {1'b0, row_prod[tccs_pkg::LINE_W-1:0]};
    mod_req.modulus  = m_q;

    unique case (state_q)
      tccs_pkg::S_IDLE: begin
        if (in_fire) begin
          m_d = m_prod[tccs_pkg::DIV_W-1:0];
          unique case (code)
            tccs_pkg::CH_TAB: begin
              tab_cnt_d = tccs_pkg::TAB_W'(tccs_pkg::TAB_STOP) - {1'b0, col_q[2:0]};
              glyph_d   = '0;
              state_d   = tccs_pkg::S_GLYPH;
            end
            tccs_pkg::CH_CR: begin
              col_d   = '0;
              state_d = tccs_pkg::S_CURSOR;
            end
            tccs_pkg::CH_BS: begin
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
              end
              state_d = tccs_pkg::S_CURSOR;
            end
            tccs_pkg::CH_LF: begin
              tab_cnt_d = '0;
              state_d   = tccs_pkg::S_LF;
            end
            tccs_pkg::CH_BEL: begin
              state_d = bell_q ? tccs_pkg::S_BELL : tccs_pkg::S_IDLE;
            end
            default: begin
              if (code >= tccs_pkg::CH_SPACE && code <= tccs_pkg::CH_TILDE) begin
                tab_cnt_d = tccs_pkg::TAB_W'(1);
                glyph_d   = code - tccs_pkg::CH_SPACE;
                state_d   = tccs_pkg::S_GLYPH;
              end else begin
                state_d = tccs_pkg::S_CURSOR;
              end
            end
          endcase
        end
      end

      // Scan line of the cursor row
      tccs_pkg::S_GLYPH: begin
        mod_req.start = 1'b1;
        state_d       = tccs_pkg::S_GMOD;
      end

      tccs_pkg::S_GMOD: begin
        if (!mod_rsp.busy) begin
          state_d = tccs_pkg::S_GEMIT;
        end
      end

      tccs_pkg::S_GEMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          act_d       = tccs_pkg::ACT_DRAW;
          oglyph_d    = glyph_q;
          line_d      = rem_line;
          ocol_d      = col_q;
          cx_d        = '0;
          cy_d        = '0;
          last_d      = 1'b0;
          tab_cnt_d   = tab_cnt_q - 1'b1;
          if (col_inc >= {1'b0, text_cols_q} || col_inc[tccs_pkg::COL_W]) begin
            col_d   = '0;
            state_d = tccs_pkg::S_LF;
          end else begin
            col_d   = col_inc[tccs_pkg::COL_W-1:0];
            state_d = (tab_cnt_q > tccs_pkg::TAB_W'(1)) ? tccs_pkg::S_GLYPH
                                                        : tccs_pkg::S_CURSOR;
          end
        end
      end

      // Linefeed: scroll at the bottom row, else step down
      tccs_pkg::S_LF: begin
        if (row_inc >= eff_rows) begin
          mod_req.start    = 1'b1;
          mod_req.dividend = {1'b0, off_q};
          state_d          = tccs_pkg::S_LMOD;
        end else begin
          row_d   = row_inc[tccs_pkg::ROW_W-1:0];
          state_d = (tab_cnt_q != '0) ? tccs_pkg::S_GLYPH : tccs_pkg::S_CURSOR;
        end
      end

      tccs_pkg::S_LMOD: begin
        if (!mod_rsp.busy) begin
          state_d = tccs_pkg::S_LEMIT;
        end
      end

      tccs_pkg::S_LEMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          act_d       = tccs_pkg::ACT_CLEAR;
          oglyph_d    = '0;
          line_d      = rem_line;
          ocol_d      = '0;
          cx_d        = '0;
          cy_d        = '0;
          last_d      = 1'b0;
          if (off_sum >= m_q) begin
            off_d = tccs_pkg::LINE_W'(off_sum - m_q);
          end else begin
            off_d = off_sum[tccs_pkg::LINE_W-1:0];
          end
          state_d = (tab_cnt_q != '0) ? tccs_pkg::S_GLYPH : tccs_pkg::S_CURSOR;
        end
      end

      // Clamped cursor position closes the character
      tccs_pkg::S_CURSOR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          act_d       = tccs_pkg::ACT_CURSOR;
          oglyph_d    = '0;
          line_d      = '0;
          ocol_d      = '0;
          cx_d        = (x_raw > x_limit_q) ? x_limit_q : x_raw;
          cy_d        = (row_prod[tccs_pkg::PIX_W-1:0] > y_limit_q) ? y_limit_q
                                                                    : row_prod[tccs_pkg::PIX_W-1:0];
          last_d      = 1'b1;
          state_d     = tccs_pkg::S_IDLE;
        end
      end

      tccs_pkg::S_BELL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          act_d       = tccs_pkg::ACT_BELL;
          oglyph_d    = '0;
          line_d      = '0;
          ocol_d      = '0;
          cx_d        = '0;
          cy_d        = '0;
          last_d      = 1'b1;
          state_d     = tccs_pkg::S_IDLE;
        end
      end

      default: state_d = tccs_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccs_pkg::S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      off_q       <= '0;
      tab_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      off_q       <= off_d;
      tab_cnt_q   <= tab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    glyph_q  <= glyph_d;
    m_q      <= m_d;
    act_q    <= act_d;
    oglyph_q <= oglyph_d;
    line_q   <= line_d;
    ocol_q   <= ocol_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    last_q   <= last_d;
  end

  assign in_i.ready        = (state_q == tccs_pkg::S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.action      = act_q;
  assign out_o.glyph_index = oglyph_q;
  assign out_o.pixel_line  = line_q;
  assign out_o.column      = ocol_q;
  assign out_o.cursor_x    = cx_q;
  assign out_o.cursor_y    = cy_q;
  assign out_o.last        = last_q;

`ifndef SYNTHESIS
  // Modulo unit only runs while the sequencer waits on it
  a_mod_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.busy |-> (state_q == tccs_pkg::S_GMOD || state_q == tccs_pkg::S_LMOD))
    else $error("modulo unit busy outside a wait state");

  // A glyph is only started with spaces or a character left to draw
  a_glyph_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccs_pkg::S_GLYPH) |-> (tab_cnt_q != '0))
    else $error("glyph started with empty count");

  // Only cursor and bell commands close a character
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |->
      (act_q == tccs_pkg::ACT_CURSOR || act_q == tccs_pkg::ACT_BELL))
    else $error("last flag on a draw or clear command");

  // A new command is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(act_q) && $stable(line_q) && out_valid_q))
    else $error("pending command overwritten");
`endif

endmodule

// ----- verif/tb_text_console_cursor_scroll.sv -----
`timescale 1ns / 1ps
// Testbench for text_console_cursor_scroll: sends character bytes, predicts each
// display command and checks every command transfer field by field.
// Depends on tccs_pkg, tccs_in_if, tccs_out_if and the block itself.
module tb_text_console_cursor_scroll;

  localparam int unsigned GLYPH_H        = 15;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned CHARS_PER_PHASE = 60;

  typedef struct {
    tccs_pkg::action_e                 action;
    logic [tccs_pkg::CODE_W-1:0]       glyph;
    logic [tccs_pkg::LINE_W-1:0]       line;
    logic [tccs_pkg::COL_W-1:0]        col;
    logic [tccs_pkg::PIX_W-1:0]        cx;
    logic [tccs_pkg::PIX_W-1:0]        cy;
    logic                              last;
  } console_cmd_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  tccs_pkg::cfg_idx_e            cfg_idx;
  logic [tccs_pkg::CFG_W-1:0]    cfg_data;

  tccs_in_if  chars_if ();
  tccs_out_if cmds_if ();

  text_console_cursor_scroll #(
    .GLYPH_HEIGHT(GLYPH_H)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (chars_if),
    .out_o     (cmds_if)
  );

  // Console model: register copies and cursor/scroll state
  int unsigned rows_reg, cols_reg, xlim_reg, ylim_reg, base_reg, bell_reg;
  int unsigned cur_row, cur_col, top_offset;
  console_cmd_t expected_cmds[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Console model
  // ---------------------------------------------------------------------------

  // Rows in use: 0 acts as 1, above 64 acts as 64
  function automatic int unsigned visible_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > tccs_pkg::MAX_ROWS) return tccs_pkg::MAX_ROWS;
    return rows_reg;
  endfunction

  // Bitmap line of text row r through the rotated scan map
  function automatic logic [tccs_pkg::LINE_W-1:0] row_pixel_line(int unsigned r);
    int unsigned span;
    span = visible_rows() * GLYPH_H;
    return tccs_pkg::LINE_W'(base_reg + (top_offset + r * GLYPH_H) % span);
  endfunction

  function automatic void push_cmd(tccs_pkg::action_e act,
                                   logic [tccs_pkg::CODE_W-1:0] glyph,
                                   logic [tccs_pkg::LINE_W-1:0] line,
                                   logic [tccs_pkg::COL_W-1:0] col,
                                   logic [tccs_pkg::PIX_W-1:0] cx,
                                   logic [tccs_pkg::PIX_W-1:0] cy);
    console_cmd_t c;
    c.action = act;
    c.glyph  = glyph;
    c.line   = line;
    c.col    = col;
    c.cx     = cx;
    c.cy     = cy;
    c.last   = 1'b0;
    expected_cmds.push_back(c);
  endfunction

  // Linefeed: scroll by clearing the top row and rotating, else move down
  function automatic void advance_line();
    int unsigned span;
    span = visible_rows() * GLYPH_H;
    if (cur_row + 1 >= visible_rows()) begin
      push_cmd(tccs_pkg::ACT_CLEAR, '0, row_pixel_line(0), '0, '0, '0);
      top_offset = (top_offset % span + GLYPH_H) % span;
    end else begin
      cur_row = (cur_row + 1) & 'h3f;
    end
  endfunction

  // Draw at the cursor, then wrap at the last column
  function automatic void draw_char(int unsigned code);
    push_cmd(tccs_pkg::ACT_DRAW, tccs_pkg::CODE_W'(code - tccs_pkg::CH_SPACE),
             row_pixel_line(cur_row), tccs_pkg::COL_W'(cur_col), '0, '0);
    cur_col++;
    if (cur_col >= cols_reg || cur_col > 127) begin
      cur_col = 0;
      advance_line();
    end
  endfunction

  function automatic void place_cursor();
    int unsigned x, y;
    x = cur_col * tccs_pkg::TAB_STOP;
    y = cur_row * GLYPH_H;
    if (x > xlim_reg) x = xlim_reg;
    if (y > ylim_reg) y = ylim_reg;
    push_cmd(tccs_pkg::ACT_CURSOR, '0, '0, '0, tccs_pkg::PIX_W'(x), tccs_pkg::PIX_W'(y));
  endfunction

  // Expected commands for one accepted character byte
  function automatic void predict_char(logic [tccs_pkg::CHAR_W-1:0] ch);
    logic [tccs_pkg::CODE_W-1:0] code;
    int unsigned                 queued;
    console_cmd_t                tail;
    code   = ch[tccs_pkg::CODE_W-1:0];
    queued = expected_cmds.size();
    if (code == tccs_pkg::CH_BEL) begin
      if (bell_reg != 0) push_cmd(tccs_pkg::ACT_BELL, '0, '0, '0, '0, '0);
    end else begin
      case (code)
        tccs_pkg::CH_TAB:
          repeat (tccs_pkg::TAB_STOP - (cur_col & (tccs_pkg::TAB_STOP - 1)))
            draw_char(tccs_pkg::CH_SPACE);
        tccs_pkg::CH_CR:  cur_col = 0;
        tccs_pkg::CH_BS:  if (cur_col > 0) cur_col--;
        tccs_pkg::CH_LF:  advance_line();
        default:
          if (code >= tccs_pkg::CH_SPACE && code <= tccs_pkg::CH_TILDE) draw_char(code);
      endcase
      place_cursor();
    end
    if (expected_cmds.size() > queued) begin
      tail = expected_cmds.pop_back();
      tail.last = 1'b1;
      expected_cmds.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One character transfer, with random idle cycles ahead of it
  task automatic send_char(input logic [tccs_pkg::CHAR_W-1:0] ch);
    if ($urandom_range(99) < idle_pct) begin
      chars_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= ch;
    do @(posedge clk); while (!chars_if.ready);
    predict_char(ch);
  endtask

  // Stop sending and wait until every expected command has arrived
  task automatic drain_commands();
    chars_if.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tccs_pkg::cfg_idx_e idx,
                           input logic [tccs_pkg::CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tccs_pkg::CFG_TEXT_ROWS: rows_reg = val[tccs_pkg::ROWS_W-1:0];
      tccs_pkg::CFG_TEXT_COLS: cols_reg = val[tccs_pkg::COL_W-1:0];
      tccs_pkg::CFG_X_LIMIT:   xlim_reg = val[tccs_pkg::PIX_W-1:0];
      tccs_pkg::CFG_Y_LIMIT:   ylim_reg = val[tccs_pkg::PIX_W-1:0];
      tccs_pkg::CFG_SCAN_BASE: base_reg = val[tccs_pkg::LINE_W-1:0];
      tccs_pkg::CFG_BELL:      bell_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [tccs_pkg::CHAR_W-1:0] random_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)
      return {1'($urandom_range(1)), tccs_pkg::CODE_W'($urandom_range(32, 126))};
    if (pick < 70) return {1'($urandom_range(1)), tccs_pkg::CH_LF};
    if (pick < 76) return {1'b0, tccs_pkg::CH_CR};
    if (pick < 81) return {1'b0, tccs_pkg::CH_BS};
    if (pick < 86) return {1'($urandom_range(1)), tccs_pkg::CH_TAB};
    if (pick < 90) return {1'b0, tccs_pkg::CH_BEL};
    return tccs_pkg::CHAR_W'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every character class at the reset settings
  task automatic test_directed_codes();
    logic [tccs_pkg::CHAR_W-1:0] codes[$];
    codes = '{8'h41, {1'b0, tccs_pkg::CH_SPACE}, {1'b0, tccs_pkg::CH_TILDE}, 8'hc1,
              8'h7f, 8'h00, 8'h1b, {1'b0, tccs_pkg::CH_BS}, {1'b0, tccs_pkg::CH_CR},
              {1'b0, tccs_pkg::CH_BS}, {1'b0, tccs_pkg::CH_TAB},
              {1'b1, tccs_pkg::CH_TAB}, {1'b0, tccs_pkg::CH_LF},
              {1'b0, tccs_pkg::CH_BEL}, 8'hff};
    foreach (codes[i]) send_char(codes[i]);
    drain_commands();
  endtask

  // Narrow two-row screen: wrap at the last column, tabs across the wrap, scroll
  task automatic test_wrap_and_scroll();
    write_reg(tccs_pkg::CFG_TEXT_ROWS, 10'd2);
    write_reg(tccs_pkg::CFG_TEXT_COLS, 10'd8);
    send_char({1'b0, tccs_pkg::CH_CR});
    repeat (3) send_char(8'h78);
    send_char({1'b0, tccs_pkg::CH_TAB});
    send_char({1'b0, tccs_pkg::CH_TAB});
    send_char({1'b0, tccs_pkg::CH_LF});
    send_char({1'b0, tccs_pkg::CH_BS});
    drain_commands();
  endtask

  // Register extremes, bell disabled, cursor clamped to zero
  task automatic test_register_extremes();
    write_reg(tccs_pkg::CFG_TEXT_ROWS, 10'h380);
    write_reg(tccs_pkg::CFG_TEXT_COLS, 10'd127);
    write_reg(tccs_pkg::CFG_X_LIMIT, 10'd0);
    write_reg(tccs_pkg::CFG_Y_LIMIT, 10'h3ff);
    write_reg(tccs_pkg::CFG_SCAN_BASE, 10'h3ff);
    write_reg(tccs_pkg::CFG_BELL, 10'h3fe);
    send_char(8'h5a);
    send_char({1'b0, tccs_pkg::CH_LF});
    send_char({1'b0, tccs_pkg::CH_BEL});
    send_char({1'b0, tccs_pkg::CH_CR});
    drain_commands();
    write_reg(tccs_pkg::CFG_TEXT_ROWS, 10'h3ff);
    write_reg(tccs_pkg::CFG_TEXT_COLS, 10'd8);
    write_reg(tccs_pkg::CFG_X_LIMIT, 10'h3ff);
    write_reg(tccs_pkg::CFG_Y_LIMIT, 10'd0);
    write_reg(tccs_pkg::CFG_SCAN_BASE, 10'd0);
    write_reg(tccs_pkg::CFG_BELL, 10'd1);
    send_char({1'b0, tccs_pkg::CH_TAB});
    send_char({1'b0, tccs_pkg::CH_BEL});
    drain_commands();
  endtask

  // Random settings per phase; cursor state carries over between phases
  task automatic test_random_configs();
    int unsigned pick;
    logic [tccs_pkg::CFG_W-1:0] rows_val, cols_val;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(9);
      if (pick < 6)      rows_val = tccs_pkg::CFG_W'($urandom_range(1, 6));
      else if (pick < 7) rows_val = tccs_pkg::CFG_W'($urandom_range(7, 64));
      else if (pick < 8) rows_val = '0;
      else               rows_val = tccs_pkg::CFG_W'($urandom_range(65, 1023));
      cols_val = ($urandom_range(3) == 0) ? tccs_pkg::CFG_W'($urandom_range(21, 127))
                                          : tccs_pkg::CFG_W'($urandom_range(8, 20));
      write_reg(tccs_pkg::CFG_TEXT_ROWS, rows_val);
      write_reg(tccs_pkg::CFG_TEXT_COLS, cols_val);
      write_reg(tccs_pkg::CFG_X_LIMIT, tccs_pkg::CFG_W'($urandom_range(1023)));
      write_reg(tccs_pkg::CFG_Y_LIMIT, tccs_pkg::CFG_W'($urandom_range(1023)));
      write_reg(tccs_pkg::CFG_SCAN_BASE, tccs_pkg::CFG_W'($urandom_range(1023)));
      write_reg(tccs_pkg::CFG_BELL, tccs_pkg::CFG_W'($urandom_range(1)));
      // one phase runs with neither side idling
      if (phase == 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 14;
        stall_pct = 14;
      end
      repeat (CHARS_PER_PHASE) send_char(random_char());
      drain_commands();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cmds_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Each command transfer against the oldest expectation
  always @(posedge clk) begin : check_cmds
    console_cmd_t want;
    if (rst_n && cmds_if.valid && cmds_if.ready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("command transfer with nothing expected");
      end else begin
        want = expected_cmds.pop_front();
        compare_field("action", cmds_if.action, want.action);
        compare_field("glyph_index", cmds_if.glyph_index, want.glyph);
        compare_field("pixel_line", cmds_if.pixel_line, want.line);
        compare_field("column", cmds_if.column, want.col);
        compare_field("cursor_x", cmds_if.cursor_x, want.cx);
        compare_field("cursor_y", cmds_if.cursor_y, want.cy);
        compare_field("last", cmds_if.last, want.last);
      end
    end
  end

  // Ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (chars_if.valid && chars_if.ready) || (cmds_if.valid && cmds_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = tccs_pkg::CFG_TEXT_ROWS;
    cfg_data           = '0;
    chars_if.valid     = 1'b0;
    chars_if.char_code = '0;
    idle_pct           = 14;
    stall_pct          = 14;
    rows_reg   = tccs_pkg::RST_TEXT_ROWS;
    cols_reg   = tccs_pkg::RST_TEXT_COLS;
    xlim_reg   = tccs_pkg::RST_X_LIMIT;
    ylim_reg   = tccs_pkg::RST_Y_LIMIT;
    base_reg   = tccs_pkg::RST_SCAN_BASE;
    bell_reg   = tccs_pkg::RST_BELL;
    cur_row    = 0;
    cur_col    = 0;
    top_offset = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_codes();
    test_wrap_and_scroll();
    test_register_extremes();
    test_random_configs();
    drain_commands();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/tccs_pkg.sv
sv/tccs_in_if.sv
sv/tccs_out_if.sv
sv/tccs_mod.sv
sv/text_console_cursor_scroll.sv
verif/tb_text_console_cursor_scroll.sv
